FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl, all clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/lkvc_pkg.sv
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

endpackage

FILE: rtl/core/lkvc_if.sv
// request channel: one get or put per beat
interface lkvc_req_if;
  import lkvc_pkg::*;

  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic signed [KEY_W-1:0]  key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

// response channel: one result per request
interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

FILE: rtl/core/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement, 16 entries.
// Each request beat is a get or a put. A get that finds its key returns the stored value
// with hit set and makes that entry most recent; a get that misses returns hit clear and
// a zero value. A put to a present key updates its value (hit set, value zero) and makes
// it most recent; a put to an absent key inserts it as most recent, replacing the least
// recent entry once the fill has reached the capacity register (0 acts as 1, values
// above 16 act as 16). Lowering capacity never drops entries; later inserts just replace.
// The store is empty after reset and needs no clearing pass. Throughput is one request
// per cycle unless rsp.ready holds the result register; each request passes the input
// register, then parallel key compare and recency-rank update into the result register.
// That compare and rank update across all entries sets the rate.
// The user must write capacity only while the cache is idle; the block does not enforce it.
`include "assert_macros.svh"

module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [CAP_W-1:0] cfg_write_data,
  lkvc_req_if.sink         req,
  lkvc_rsp_if.source       rsp
);

  // configuration
  logic [CAP_W-1:0] capacity;

  // entry storage: keys and data need no reset, only valid/rank/count do
  logic [ENTRIES-1:0]       entry_valid;
  logic [KEY_W-1:0]         entry_key  [ENTRIES];
  logic [DATA_W-1:0]        entry_data [ENTRIES];
  logic [IDX_W-1:0]         rank       [ENTRIES];
  logic [CNT_W-1:0]         used_count;

  // input register stage
  logic                     s1_valid;
  action_t                  s1_action;
  logic [KEY_W-1:0]         s1_key;
  logic [DATA_W-1:0]        s1_value;

  // result register
  logic                     out_valid;
  logic                     out_hit;
  logic [DATA_W-1:0]        out_value;

  // lookup and update decode
  logic                     advance;
  logic [CNT_W-1:0]         eff_cap;
  logic [ENTRIES-1:0]       match_vec;
  logic [ENTRIES-1:0]       victim_vec;
  logic [IDX_W-1:0]         match_idx;
  logic [IDX_W-1:0]         victim_idx;
  logic [IDX_W-1:0]         free_idx;
  logic                     any_hit;
  logic                     full;
  logic                     do_update;
  logic                     insert_new;
  logic [IDX_W-1:0]         sel_idx;
  logic [CNT_W-1:0]         sel_rank;
  logic [IDX_W-1:0]         rank_next [ENTRIES];

  // the stage moves when the result register is empty or being drained this cycle
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.read_value = out_value;

  // clamp the capacity register into 1..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(capacity) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  // parallel compare; valid entries hold distinct keys and distinct ranks,
  // so the least recent one is the entry ranked used_count - 1
  always_comb begin
    match_idx  = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i]  = entry_valid[i] && (entry_key[i] == s1_key);
      victim_vec[i] = entry_valid[i] && (CNT_W'(rank[i]) == (used_count - CNT_W'(1)));
      if (match_vec[i]) begin
        match_idx = IDX_W'(i);
      end
      if (victim_vec[i]) begin
        victim_idx = IDX_W'(i);
      end
    end
    // lowest free slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit    = |match_vec;
  assign full       = used_count >= eff_cap;
  assign do_update  = advance && (any_hit || (s1_action == ACT_PUT));
  assign insert_new = (s1_action == ACT_PUT) && !any_hit && !full;

  // slot to promote and its old rank; a fresh insert ages every valid entry
  always_comb begin
    if (any_hit) begin
      sel_idx  = match_idx;
      sel_rank = CNT_W'(rank[match_idx]);
    end else if (full) begin
      sel_idx  = victim_idx;
      sel_rank = used_count - CNT_W'(1);
    end else begin
      sel_idx  = free_idx;
      sel_rank = used_count;
    end
  end

  // promote: the selected slot becomes rank 0, everything more recent ages by one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (IDX_W'(i) == sel_idx) begin
        rank_next[i] = '0;
      end else if (entry_valid[i] && (CNT_W'(rank[i]) < sel_rank)) begin
        rank_next[i] = rank[i] + IDX_W'(1);
      end else begin
        rank_next[i] = rank[i];
      end
    end
  end

  // control state, configuration and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      entry_valid <= '0;
      used_count  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (do_update) begin
        for (int i = 0; i < ENTRIES; i++) begin
          rank[i] <= rank_next[i];
        end
        if (insert_new) begin
          entry_valid[sel_idx] <= 1'b1;
          used_count           <= used_count + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_action <= req.action;
      s1_key    <= req.key;
      s1_value  <= req.value;
    end
    if (advance) begin
      out_hit   <= any_hit;
      out_value <= (any_hit && (s1_action == ACT_GET)) ? entry_data[match_idx] : '0;
    end
    if (do_update && (s1_action == ACT_PUT)) begin
      entry_key[sel_idx]  <= s1_key;
      entry_data[sel_idx] <= s1_value;
    end
  end

  // fill count tracks the valid bits exactly
  `ASSERT_ALWAYS(a_count_matches_valid, $countones(entry_valid) == int'(used_count), "used_count disagrees with valid bits")
  // a key is never stored twice
  `ASSERT_ALWAYS(a_key_unique, !s1_valid || $onehot0(match_vec), "key present in more than one entry")
  // fill never runs past the entry count
  `ASSERT_ALWAYS(a_count_bound, int'(used_count) <= ENTRIES, "used_count exceeds entry count")
  // every item that leaves the input stage lands in the result register
  `ASSERT_NEXT(a_result_loaded, advance, out_valid, "advanced item produced no result")

endmodule
